[hdl/bpc_pkg.sv]
// shared types, constants and phase encoding for the button press classifier
package bpc_pkg;

	localparam int PIN_BITS = 4;
	localparam int PHASE_W = 3;
	localparam int OUT_BUTTONS = 4;
	localparam int TIME_W = 32;
	localparam int THR_W = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int IN_TDATA_W = 40;
	localparam int OUT_TDATA_W = 16;

	localparam logic [THR_W-1:0] SHORT_PRESS_RESET = 16'd100;
	localparam logic [THR_W-1:0] LONG_PRESS_RESET = 16'd2000;

	localparam logic [CFG_INDEX_W-1:0] REG_SHORT_PRESS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 2'd1;

	localparam logic [PHASE_W-1:0] PH_IDLE = 3'd0;
	localparam logic [PHASE_W-1:0] PH_ACTIVE = 3'd1;
	localparam logic [PHASE_W-1:0] PH_SHORT_PRESS = 3'd2;
	localparam logic [PHASE_W-1:0] PH_SHORT_HOLD = 3'd3;
	localparam logic [PHASE_W-1:0] PH_LONG_PRESS = 3'd4;
	localparam logic [PHASE_W-1:0] PH_LONG_HOLD = 3'd5;

	typedef enum logic [5:0] {
		ST_IDLE        = 6'b000001,
		ST_ACTIVE      = 6'b000010,
		ST_SHORT_PRESS = 6'b000100,
		ST_SHORT_HOLD  = 6'b001000,
		ST_LONG_PRESS  = 6'b010000,
		ST_LONG_HOLD   = 6'b100000
	} btn_state_t;

	typedef struct packed {
		logic [THR_W-1:0] short_ms;
		logic [THR_W-1:0] long_ms;
	} thresholds_t;

	function automatic logic [PHASE_W-1:0] phase_code(input btn_state_t st);
		logic [PHASE_W-1:0] code;
		case (st)
			ST_ACTIVE: code = PH_ACTIVE;
			ST_SHORT_PRESS: code = PH_SHORT_PRESS;
			ST_SHORT_HOLD: code = PH_SHORT_HOLD;
			ST_LONG_PRESS: code = PH_LONG_PRESS;
			ST_LONG_HOLD: code = PH_LONG_HOLD;
			default: code = PH_IDLE;
		endcase
		return code;
	endfunction

endpackage

[hdl/button_press_classifier.sv]
// top level: input stage, per-button machines, result register and config registers
//
//   channel  | dir | beat
//   s_axis   | in  | one tick: pins_raw, now_ms
//   m_axis   | out | one result: button_phases
//   cfg      | in  | one register write: index, data
//
// one result per tick; a tick is held in the input register until it advances, then the
// phase machines update and the result register loads in the same edge
// a new tick can be taken every cycle while the result register drains
// reset clears all phases to idle, start times to zero, thresholds to 100 / 2000
// a stalled result holds the input stage, which then holds s_axis_tready low
module button_press_classifier #(
	parameter int NUM_BUTTONS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [bpc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // pins_raw[3:0], now_ms[35:4]
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [bpc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // button_phases[11:0]
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bpc_pkg::THR_W-1:0]        cfg_data
);
	import bpc_pkg::*;

	logic s1_valid_q;
	logic [PIN_BITS-1:0] pins_s1;
	logic [TIME_W-1:0] now_s1;
	logic advance;
	logic out_valid_q;
	logic [OUT_BUTTONS*PHASE_W-1:0] out_data_q;
	logic [OUT_BUTTONS*PHASE_W-1:0] phases_packed;
	logic [PHASE_W-1:0] codes [NUM_BUTTONS];
	thresholds_t thr_q;

	assign advance = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.short_ms <= SHORT_PRESS_RESET;
			thr_q.long_ms <= LONG_PRESS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SHORT_PRESS: thr_q.short_ms <= cfg_data;
				REG_LONG_PRESS: thr_q.long_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			pins_s1 <= s_axis_tdata[PIN_BITS-1:0];
			now_s1 <= s_axis_tdata[PIN_BITS +: TIME_W];
		end
	end

	genvar i;
	generate
		for (i = 0; i < NUM_BUTTONS; i++) begin : g_btn
			logic down;
			if (i < PIN_BITS) begin : g_pin
				assign down = !pins_s1[i];
			end else begin : g_nopin
				assign down = 1'b0;
			end
			bpc_button u_button (
				.clk        (clk),
				.arst_n     (arst_n),
				.advance    (advance),
				.down       (down),
				.now_ms     (now_s1),
				.thr        (thr_q),
				.phase_next (codes[i])
			);
		end
		for (i = 0; i < OUT_BUTTONS; i++) begin : g_pack
			if (i < NUM_BUTTONS) begin : g_used
				assign phases_packed[i*PHASE_W +: PHASE_W] = codes[i];
			end else begin : g_unused
				assign phases_packed[i*PHASE_W +: PHASE_W] = PH_IDLE;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= phases_packed;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(OUT_TDATA_W-OUT_BUTTONS*PHASE_W){1'b0}}, out_data_q};

endmodule

[hdl/bpc_button.sv]
// per-button phase machine with press start time and held-time compare
module bpc_button (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  logic                     down,
	input  logic [bpc_pkg::TIME_W-1:0] now_ms,
	input  bpc_pkg::thresholds_t     thr,
	output logic [bpc_pkg::PHASE_W-1:0] phase_next
);
	import bpc_pkg::*;

	btn_state_t state_q;
	btn_state_t state_d;
	logic [TIME_W-1:0] start_q;
	logic [TIME_W-1:0] held;
	logic short_hit;
	logic long_hit;

	assign held = now_ms - start_q;
	assign short_hit = held >= {{(TIME_W-THR_W){1'b0}}, thr.short_ms};
	assign long_hit = held >= {{(TIME_W-THR_W){1'b0}}, thr.long_ms};

	always_comb begin
		state_d = ST_IDLE;
		if (down) begin
			case (state_q)
				ST_IDLE: state_d = ST_ACTIVE;
				ST_ACTIVE: state_d = short_hit ? ST_SHORT_PRESS : ST_ACTIVE;
				ST_SHORT_PRESS: state_d = ST_SHORT_HOLD;
				ST_SHORT_HOLD: state_d = long_hit ? ST_LONG_PRESS : ST_SHORT_HOLD;
				ST_LONG_PRESS: state_d = ST_LONG_HOLD;
				ST_LONG_HOLD: state_d = ST_LONG_HOLD;
				default: state_d = ST_IDLE;
			endcase
		end
	end

	assign phase_next = phase_code(state_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= '0;
		end else if (advance) begin
			state_q <= state_d;
			if (state_q == ST_IDLE && state_d == ST_ACTIVE) begin
				start_q <= now_ms;
			end
		end
	end

endmodule

[hdl/bpc_checker.sv]
// port-level checks for the button press classifier, bound to the top level
module bpc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [bpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import bpc_pkg::*;

	// result beat holds while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result data changed while stalled");

	// every phase field carries a defined code
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:1] != 2'b11) && (m_axis_tdata[5:4] != 2'b11)
			&& (m_axis_tdata[8:7] != 2'b11) && (m_axis_tdata[11:10] != 2'b11))
		else $error("undefined phase code in result");

	// padding above the phase fields stays zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_BUTTONS*PHASE_W] == '0)
		else $error("nonzero padding in result");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

[tb/button_press_classifier_tb.sv]
// self-checking testbench for button_press_classifier: per-button phase prediction on directed and random ticks
module button_press_classifier_tb;
	import bpc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASES_W = OUT_BUTTONS * PHASE_W;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;  // pins_raw[3:0], now_ms[35:4]
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;  // button_phases[11:0]
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [THR_W-1:0] cfg_data;

	logic [PHASE_W-1:0] btn_phase [OUT_BUTTONS];
	logic [TIME_W-1:0] btn_start [OUT_BUTTONS];
	logic [THR_W-1:0] short_thr;
	logic [THR_W-1:0] long_thr;
	logic [PHASES_W-1:0] phases_due [$];
	logic [PHASES_W-1:0] want;

	logic [PIN_BITS-1:0] cur_pins = '1;
	logic [TIME_W-1:0] cur_now = '0;
	int unsigned step_max = 1;
	bit idle_on = 1'b1;
	int hold_req = 0;
	int unsigned ticks_sent = 0;
	int unsigned results_seen = 0;
	int unsigned reg_writes = 0;
	int unsigned mismatches = 0;
	int unsigned short_presses = 0;
	int unsigned long_presses = 0;
	int unsigned quiet_cycles = 0;

	button_press_classifier dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [PHASES_W-1:0] advance_buttons(input logic [PIN_BITS-1:0] pins,
			input logic [TIME_W-1:0] now);
		logic [PHASES_W-1:0] phases;
		logic [TIME_W-1:0] held;
		logic [PHASE_W-1:0] nxt;
		logic down;
		phases = '0;
		for (int b = 0; b < OUT_BUTTONS; b++) begin
			down = (b < PIN_BITS) ? !pins[b] : 1'b0;
			held = now - btn_start[b];
			if (btn_phase[b] == PH_IDLE)
				nxt = down ? PH_ACTIVE : PH_IDLE;
			else if (!down)
				nxt = PH_IDLE;
			else begin
				case (btn_phase[b])
					PH_ACTIVE: nxt = (held >= short_thr) ? PH_SHORT_PRESS : PH_ACTIVE;
					PH_SHORT_PRESS: nxt = PH_SHORT_HOLD;
					PH_SHORT_HOLD: nxt = (held >= long_thr) ? PH_LONG_PRESS : PH_SHORT_HOLD;
					PH_LONG_PRESS: nxt = PH_LONG_HOLD;
					PH_LONG_HOLD: nxt = PH_LONG_HOLD;
					default: nxt = PH_IDLE;
				endcase
			end
			if (btn_phase[b] == PH_IDLE && nxt == PH_ACTIVE)
				btn_start[b] = now;
			if (nxt == PH_SHORT_PRESS)
				short_presses++;
			if (nxt == PH_LONG_PRESS)
				long_presses++;
			btn_phase[b] = nxt;
			phases[b*PHASE_W +: PHASE_W] = nxt;
		end
		return phases;
	endfunction

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH: %s", msg);
	endtask

	task automatic send_tick(input logic [PIN_BITS-1:0] pins, input logic [TIME_W-1:0] now);
		int gap;
		gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_TDATA_W - PIN_BITS - TIME_W){1'b0}}, now, pins};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		phases_due.push_back(advance_buttons(pins, now));
		ticks_sent++;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] reg_index,
			input logic [THR_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= reg_index;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		case (reg_index)
			REG_SHORT_PRESS: short_thr = value;
			REG_LONG_PRESS: long_thr = value;
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (phases_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly slow pin toggles with steady time, now and then a jump or garbage pins
	task automatic random_tick();
		if ($urandom_range(0, 49) == 0)
			cur_now = $urandom;
		else
			cur_now += $urandom_range(0, step_max);
		if ($urandom_range(0, 19) == 0)
			cur_pins = PIN_BITS'($urandom);
		else begin
			for (int b = 0; b < PIN_BITS; b++)
				if ($urandom_range(0, 15) == 0)
					cur_pins[b] = ~cur_pins[b];
		end
		send_tick(cur_pins, cur_now);
	endtask

	task automatic run_random(input int n, input logic [THR_W-1:0] short_ms,
			input logic [THR_W-1:0] long_ms, input bit idle);
		drain_results();
		write_reg(REG_SHORT_PRESS, short_ms);
		write_reg(REG_LONG_PRESS, long_ms);
		if ($urandom_range(0, 1))
			write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, THR_W'($urandom));
		idle_on = idle;
		step_max = ((short_ms > long_ms ? short_ms : long_ms) >> 3) + 1;
		repeat (n) random_tick();
	endtask

	task automatic test_default_thresholds();
		send_tick(4'hF, 32'd0);
		send_tick(4'h0, 32'd10);
		send_tick(4'h0, 32'd109);
		send_tick(4'h0, 32'd110);
		send_tick(4'h0, 32'd111);
		send_tick(4'h0, 32'd2109);
		send_tick(4'h0, 32'd2110);
		send_tick(4'h0, 32'd2111);
		send_tick(4'b0010, 32'd2112);
		send_tick(4'hF, 32'd2113);
	endtask

	// zero thresholds still step one phase per tick
	task automatic test_zero_thresholds();
		drain_results();
		write_reg(REG_SHORT_PRESS, 16'h0000);
		write_reg(REG_LONG_PRESS, 16'h0000);
		repeat (5) send_tick(4'h0, 32'd7);
		send_tick(4'hF, 32'd7);
	endtask

	// held time across the 32-bit wrap and with a start time ahead of now
	task automatic test_time_wrap();
		drain_results();
		write_reg(REG_SHORT_PRESS, 16'hFFFF);
		write_reg(REG_LONG_PRESS, 16'hFFFF);
		write_reg(REG_SPARE_2, 16'h0000);
		write_reg(REG_SPARE_3, 16'h0001);
		send_tick(4'hE, 32'hFFFF_FFF0);
		send_tick(4'hE, 32'h0000_FFEE);
		send_tick(4'hE, 32'h0000_FFEF);
		send_tick(4'hC, 32'd1000);
		send_tick(4'hC, 32'd500);
		send_tick(4'hF, 32'd501);
	endtask

	task automatic test_random_mix();
		run_random(250, THR_W'($urandom_range(0, 300)), THR_W'($urandom_range(0, 1500)), 1'b1);
		run_random(200, 16'h0000, 16'h0000, 1'b1);
		run_random(250, 16'hFFFF, 16'hFFFF, 1'b1);
		run_random(250, THR_W'($urandom_range(0, 300)), THR_W'($urandom_range(0, 1500)), 1'b0);
		run_random(250, THR_W'($urandom_range(0, 2000)), THR_W'($urandom_range(0, 400)), 1'b1);
	endtask

	// receiver stalls long while ticks keep coming, so the block backs up
	task automatic test_backpressure();
		run_random(40, THR_W'($urandom_range(0, 300)), THR_W'($urandom_range(0, 1500)), 1'b0);
		hold_req = LONG_HOLD_CYCLES;
		repeat (210) random_tick();
	endtask

	task automatic test_unpaced_tail();
		run_random(300, THR_W'($urandom_range(0, 300)), THR_W'($urandom_range(0, 1500)), 1'b0);
	endtask

	initial begin : sink_ready
		int stall_left;
		stall_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				m_axis_tready <= 1'b0;
				stall_left = hold_req;
				hold_req = 0;
			end else if (stall_left > 0) begin
				stall_left--;
				if (stall_left == 0)
					m_axis_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				m_axis_tready <= 1'b0;
				stall_left = $urandom_range(1, 12);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (phases_due.size() == 0)
				flag_mismatch($sformatf("result beat %0d with no tick pending, data %04h",
					results_seen, m_axis_tdata));
			else begin
				want = phases_due.pop_front();
				for (int b = 0; b < OUT_BUTTONS; b++)
					if (m_axis_tdata[b*PHASE_W +: PHASE_W] !== want[b*PHASE_W +: PHASE_W])
						flag_mismatch($sformatf("result %0d button %0d: expected phase %0d, got %0d",
							results_seen, b, want[b*PHASE_W +: PHASE_W],
							m_axis_tdata[b*PHASE_W +: PHASE_W]));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results pending",
				WATCHDOG_LIMIT, phases_due.size());
			$display("button_press_classifier_tb: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_SHORT_PRESS;
		cfg_data <= '0;
		short_thr = SHORT_PRESS_RESET;
		long_thr = LONG_PRESS_RESET;
		for (int b = 0; b < OUT_BUTTONS; b++) begin
			btn_phase[b] = PH_IDLE;
			btn_start[b] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_thresholds();
		test_zero_thresholds();
		test_time_wrap();
		test_random_mix();
		test_backpressure();
		test_unpaced_tail();
		drain_results();

		$display("ran %0d ticks with %0d register writes, checked %0d result beats",
			ticks_sent, reg_writes, results_seen);
		$display("saw %0d short presses and %0d long presses, %0d mismatches",
			short_presses, long_presses, mismatches);
		if (mismatches == 0)
			$display("button_press_classifier_tb: done, clean");
		else
			$display("button_press_classifier_tb: done, errors");
		$finish;
	end

endmodule

[sim.f]
hdl/bpc_pkg.sv
hdl/bpc_button.sv
hdl/button_press_classifier.sv
hdl/bpc_checker.sv
tb/button_press_classifier_tb.sv
